// ===== src/bchc_pkg.sv =====
`default_nettype none
package bchc_pkg;

	localparam int unsigned TICK_W = 16;
	localparam int unsigned PHASE_W = 4;
	localparam int unsigned EVENT_W = 3;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [EVENT_W-1:0] event_t;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 3'd4;

	// register reset values
	localparam logic RST_PRESS_LEVEL = 1'b0;
	localparam tick_t RST_DEBOUNCE = 16'd20;
	localparam tick_t RST_CLICK = 16'd300;
	localparam tick_t RST_RELEASE = 16'd300;
	localparam tick_t RST_HOLD = 16'd2000;
	// debounced level starts released
	localparam logic RST_LEVEL = ~RST_PRESS_LEVEL;

	localparam tick_t TICK_MAX = '1;

	// phase codes
	localparam phase_t PH_IDLE = 4'd0;
	localparam phase_t PH_PRESS = 4'd1;
	localparam phase_t PH_WAIT_SINGLE = 4'd2;
	localparam phase_t PH_WAIT_DOUBLE = 4'd3;
	localparam phase_t PH_WAIT_HOLD = 4'd4;
	localparam phase_t PH_WAIT_REL = 4'd5;
	localparam phase_t PH_HOLD = 4'd6;
	localparam phase_t PH_SINGLE = 4'd7;
	localparam phase_t PH_DOUBLE = 4'd8;
	localparam phase_t PH_RELEASE = 4'd9;

	// event codes
	localparam event_t EV_NONE = 3'd0;
	localparam event_t EV_SINGLE = 3'd1;
	localparam event_t EV_DOUBLE = 3'd2;
	localparam event_t EV_HOLD = 3'd3;
	localparam event_t EV_RELEASE = 3'd4;

	typedef struct packed {
		logic press_level;
		tick_t debounce_ticks;
		tick_t click_ticks;
		tick_t release_ticks;
		tick_t hold_ticks;
	} cfg_t;

	function automatic tick_t sat_inc(input tick_t v);
		return (v == TICK_MAX) ? v : v + tick_t'(1);
	endfunction

endpackage
`default_nettype wire

// ===== src/bchc_debounce.sv =====
`default_nettype none
module bchc_debounce
	import bchc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic pin_level,
	input wire logic edge_seen,
	input wire cfg_t cfg,
	output logic level_n
);

	logic debouncing_q;
	tick_t elapsed_q;
	logic level_q;

	logic deb_mid;
	tick_t el_mid;
	logic deb_n;
	tick_t el_n;

	always_comb begin
		if (edge_seen && !debouncing_q) begin
			deb_mid = 1'b1;
			el_mid = '0;
		end else begin
			deb_mid = debouncing_q;
			el_mid = debouncing_q ? sat_inc(elapsed_q) : elapsed_q;
		end
		deb_n = deb_mid;
		el_n = el_mid;
		level_n = level_q;
		if (deb_mid && (el_mid >= cfg.debounce_ticks)) begin
			level_n = pin_level;
			deb_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debouncing_q <= 1'b0;
			elapsed_q <= '0;
			level_q <= RST_LEVEL;
		end else if (step) begin
			debouncing_q <= deb_n;
			elapsed_q <= el_n;
			level_q <= level_n;
		end
	end

	// a wait with zero length never survives past its tick
	a_zero_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.debounce_ticks == '0) |-> !deb_n)
		else $error("debounce wait left open with zero length");

	// the elapsed count only moves while a wait is open
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !debouncing_q && !edge_seen) |=> (elapsed_q == $past(elapsed_q)))
		else $error("debounce count moved while stable");

	// level only changes at the end of a wait
	a_level_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(level_n != level_q) |-> (deb_mid && !deb_n))
		else $error("level changed outside a debounce sample");

endmodule
`default_nettype wire

// ===== src/bchc_phase.sv =====
`default_nettype none
module bchc_phase
	import bchc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic level_n,
	input wire cfg_t cfg,
	output event_t ev_n,
	output logic power_n
);

	phase_t phase_q;
	tick_t elapsed_q;
	logic power_q;

	phase_t phase_n;
	tick_t el_inc;
	tick_t el_n;
	logic pressed;

	always_comb begin
		el_inc = sat_inc(elapsed_q);
		pressed = (level_n == cfg.press_level);
		phase_n = phase_q;
		el_n = el_inc;
		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					phase_n = PH_PRESS;
					el_n = '0;
				end
			end
			PH_PRESS: begin
				if (!pressed) begin
					if (el_inc < cfg.click_ticks) begin
						phase_n = PH_WAIT_SINGLE;
						el_n = '0;
					end else begin
						phase_n = PH_IDLE;
					end
				end else if (el_inc >= cfg.click_ticks) begin
					phase_n = PH_WAIT_HOLD;
				end
			end
			PH_WAIT_SINGLE: begin
				if (el_inc >= cfg.release_ticks) begin
					if (!pressed)
						phase_n = PH_SINGLE;
				end else if (pressed) begin
					phase_n = PH_WAIT_DOUBLE;
					el_n = '0;
				end
			end
			PH_WAIT_DOUBLE: begin
				if (!pressed)
					phase_n = (el_inc < cfg.click_ticks) ? PH_DOUBLE : PH_IDLE;
				else if (el_inc >= cfg.click_ticks)
					phase_n = PH_IDLE;
			end
			PH_WAIT_HOLD: begin
				if (el_inc >= cfg.hold_ticks)
					phase_n = pressed ? PH_HOLD : PH_IDLE;
			end
			PH_WAIT_REL: begin
				if (!pressed && (el_inc >= cfg.release_ticks))
					phase_n = PH_RELEASE;
			end
			PH_HOLD: begin
				phase_n = PH_WAIT_REL;
				el_n = '0;
			end
			default: begin
				// event phases last one tick
				phase_n = PH_IDLE;
			end
		endcase

		ev_n = EV_NONE;
		power_n = power_q;
		case (phase_n)
			PH_SINGLE: ev_n = EV_SINGLE;
			PH_DOUBLE: ev_n = EV_DOUBLE;
			PH_HOLD: begin
				ev_n = EV_HOLD;
				power_n = ~power_q;
			end
			PH_RELEASE: ev_n = EV_RELEASE;
			default: ev_n = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			elapsed_q <= '0;
			power_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			elapsed_q <= el_n;
			power_q <= power_n;
		end
	end

	// power flips exactly on a hold
	a_power_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(power_n != power_q) |-> (ev_n == EV_HOLD))
		else $error("power flag changed without a hold");

	// hold always moves on to wait-release with a fresh timer
	a_hold_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_HOLD) |=> (phase_q == PH_WAIT_REL && elapsed_q == '0))
		else $error("hold did not pass to wait-release");

	// state only moves on a step
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> (phase_q == $past(phase_q) && power_q == $past(power_q)))
		else $error("phase moved without a tick");

endmodule
`default_nettype wire

// ===== src/button_click_hold_classifier.sv =====
`default_nettype none
// Button classifier: each input beat is one millisecond tick carrying the raw
// pin level and an edge flag; each tick yields exactly one result beat with the
// event code (none, single click, double click, hold, release), the power-off
// flag and the debounced level. A beat is taken into an input register, the
// debounce and phase logic act on it combinationally and the result lands in an
// output register, and one beat is accepted every clock while the result side
// keeps up. in_stall rises only when a result is waiting and out_stall is high.
// Configuration is written through cfg_we/cfg_index/cfg_data and should change
// only while no tick is in flight.
module button_click_hold_classifier
	import bchc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [TICK_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic pin_level,
	input wire logic edge_seen,
	output logic out_valid,
	input wire logic out_stall,
	output logic [EVENT_W-1:0] event_res,
	output logic power_off,
	output logic level_now
);

	cfg_t cfg_q;

	logic valid_s1;
	logic pin_s1;
	logic edge_s1;

	logic out_valid_q;
	event_t event_q;
	logic power_q;
	logic level_q;

	logic advance;
	logic step;
	logic level_n;
	event_t ev_n;
	logic power_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level <= RST_PRESS_LEVEL;
			cfg_q.debounce_ticks <= RST_DEBOUNCE;
			cfg_q.click_ticks <= RST_CLICK;
			cfg_q.release_ticks <= RST_RELEASE;
			cfg_q.hold_ticks <= RST_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRESS_LEVEL: cfg_q.press_level <= cfg_data[0];
				CFG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				CFG_CLICK: cfg_q.click_ticks <= cfg_data;
				CFG_RELEASE: cfg_q.release_ticks <= cfg_data;
				CFG_HOLD: cfg_q.hold_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register free or being drained this cycle
	assign advance = !out_valid_q || !out_stall;
	assign step = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_s1 <= pin_level;
			edge_s1 <= edge_seen;
		end
	end

	bchc_debounce u_debounce (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.pin_level(pin_s1),
		.edge_seen(edge_s1),
		.cfg(cfg_q),
		.level_n(level_n)
	);

	bchc_phase u_phase (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.level_n(level_n),
		.cfg(cfg_q),
		.ev_n(ev_n),
		.power_n(power_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q <= ev_n;
			power_q <= power_n;
			level_q <= level_n;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign power_off = power_q;
	assign level_now = level_q;

	// a stalled tick stays in the input register
	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("input beat dropped under stall");

	// every stepped tick shows up as a result next cycle
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("stepped tick produced no result");

	// stall toward the source only with a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import bchc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int MAX_SHOWN = 10;
	localparam int RAND_SPAN_CAP = 40;

	typedef struct packed {
		logic pin;
		logic edg;
	} button_tick_t;

	typedef struct packed {
		event_t ev;
		logic pwr;
		logic lvl;
	} tick_report_t;

	typedef enum int {G_CLICK, G_DOUBLE, G_HOLD, G_NOISE, G_LEVEL} gesture_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PRESS_LEVEL;
	logic [TICK_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic pin_level = 1'b0;
	logic edge_seen = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [EVENT_W-1:0] event_res;
	logic power_off;
	logic level_now;

	button_click_hold_classifier u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_level(pin_level),
		.edge_seen(edge_seen),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.power_off(power_off),
		.level_now(level_now)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// classifier copy: registers
	logic cfg_act = 1'b0;
	tick_t cfg_deb = 16'd20;
	tick_t cfg_click = 16'd300;
	tick_t cfg_rel = 16'd300;
	tick_t cfg_hold = 16'd2000;

	// classifier copy: state
	logic deb_busy = 1'b0;
	tick_t deb_count = '0;
	logic deb_level = 1'b1;
	phase_t ph = PH_IDLE;
	tick_t ph_count = '0;
	logic pwr_off = 1'b0;

	button_tick_t ticks_to_send[$];
	tick_report_t tick_reports[$];
	int ticks_pushed = 0;
	int ticks_taken = 0;
	int errors = 0;

	int burst_left = 0;
	int gap_left = 0;
	button_tick_t next_tick;

	int holdoff_reqs = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;
	stall_kind_t stall_kind = STALL_NONE;
	int stall_kind_left = 0;

	tick_report_t want;
	int idle_cycles = 0;

	function automatic tick_t bump(input tick_t v);
		return (v == '1) ? v : v + 16'd1;
	endfunction

	function automatic int clip(input tick_t v);
		return (v > RAND_SPAN_CAP) ? RAND_SPAN_CAP : int'(v);
	endfunction

	task automatic classify_tick(input logic pin, input logic edg);
		logic pressed;
		tick_report_t rep;
		if (deb_busy)
			deb_count = bump(deb_count);
		ph_count = bump(ph_count);
		// an edge only opens a new wait while the line is settled
		if (edg && !deb_busy) begin
			deb_busy = 1'b1;
			deb_count = '0;
		end
		if (deb_busy && deb_count >= cfg_deb) begin
			deb_level = pin;
			deb_busy = 1'b0;
		end
		pressed = (deb_level == cfg_act);
		case (ph)
			PH_IDLE: begin
				if (pressed) begin
					ph = PH_PRESS;
					ph_count = '0;
				end
			end
			PH_PRESS: begin
				if (!pressed) begin
					if (ph_count < cfg_click) begin
						ph = PH_WAIT_SINGLE;
						ph_count = '0;
					end else begin
						ph = PH_IDLE;
					end
				end else if (ph_count >= cfg_click) begin
					// timer keeps running into the hold wait
					ph = PH_WAIT_HOLD;
				end
			end
			PH_WAIT_SINGLE: begin
				if (ph_count >= cfg_rel) begin
					if (!pressed)
						ph = PH_SINGLE;
				end else if (pressed) begin
					ph = PH_WAIT_DOUBLE;
					ph_count = '0;
				end
			end
			PH_WAIT_DOUBLE: begin
				if (!pressed)
					ph = (ph_count < cfg_click) ? PH_DOUBLE : PH_IDLE;
				else if (ph_count >= cfg_click)
					ph = PH_IDLE;
			end
			PH_WAIT_HOLD: begin
				if (ph_count >= cfg_hold)
					ph = pressed ? PH_HOLD : PH_IDLE;
			end
			PH_WAIT_REL: begin
				if (!pressed && ph_count >= cfg_rel)
					ph = PH_RELEASE;
			end
			PH_HOLD: begin
				ph = PH_WAIT_REL;
				ph_count = '0;
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase
		rep.ev = EV_NONE;
		case (ph)
			PH_SINGLE: rep.ev = EV_SINGLE;
			PH_DOUBLE: rep.ev = EV_DOUBLE;
			PH_HOLD: begin
				rep.ev = EV_HOLD;
				pwr_off = ~pwr_off;
			end
			PH_RELEASE: rep.ev = EV_RELEASE;
			default: ;
		endcase
		rep.pwr = pwr_off;
		rep.lvl = deb_level;
		tick_reports.push_back(rep);
	endtask

	// edge on the first beat, chatter on the next few, then a steady level
	task automatic push_segment(input logic lvl, input int n, input int chatter);
		button_tick_t t;
		for (int k = 0; k < ((n < 1) ? 1 : n); k++) begin
			if (k == 0) begin
				t.pin = lvl;
				t.edg = 1'b1;
			end else if (k <= chatter) begin
				t.pin = 1'($urandom_range(0, 1));
				t.edg = 1'($urandom_range(0, 1));
			end else begin
				t.pin = lvl;
				t.edg = 1'b0;
			end
			ticks_to_send.push_back(t);
			ticks_pushed++;
		end
	endtask

	task automatic push_gesture();
		int c;
		int r;
		int h;
		int d;
		int pick;
		int chatter;
		int span;
		gesture_t g;
		button_tick_t t;
		c = clip(cfg_click);
		r = clip(cfg_rel);
		h = clip(cfg_hold);
		d = clip(cfg_deb);
		pick = $urandom_range(0, 9);
		g = (pick < 3) ? G_CLICK : (pick < 5) ? G_DOUBLE : (pick < 7) ? G_HOLD :
			(pick < 8) ? G_NOISE : G_LEVEL;
		chatter = ($urandom_range(0, 3) == 0) ? $urandom_range(0, d + 1) : 0;
		case (g)
			G_CLICK: begin
				push_segment(cfg_act, $urandom_range(1, c + d + 1), chatter);
				push_segment(~cfg_act, $urandom_range(1, r + d + 3), chatter);
			end
			G_DOUBLE: begin
				push_segment(cfg_act, $urandom_range(1, c + 1), chatter);
				push_segment(~cfg_act, $urandom_range(1, r + 1), 0);
				push_segment(cfg_act, $urandom_range(1, c + 1), 0);
				push_segment(~cfg_act, $urandom_range(r, r + d + 4), chatter);
			end
			G_HOLD: begin
				span = ((c > h) ? c : h) + d + 4;
				push_segment(cfg_act, $urandom_range(c, span), chatter);
				push_segment(~cfg_act, $urandom_range(1, r + d + 4), chatter);
			end
			G_NOISE: begin
				repeat ($urandom_range(1, 6)) begin
					t.pin = 1'($urandom_range(0, 1));
					t.edg = 1'($urandom_range(0, 1));
					ticks_to_send.push_back(t);
					ticks_pushed++;
				end
			end
			default: begin
				push_segment(1'($urandom_range(0, 1)), $urandom_range(1, c + h + 2), chatter);
			end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input tick_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PRESS_LEVEL: cfg_act = val[0];
			CFG_DEBOUNCE: cfg_deb = val;
			CFG_CLICK: cfg_click = val;
			CFG_RELEASE: cfg_rel = val;
			CFG_HOLD: cfg_hold = val;
			default: ;
		endcase
	endtask

	task automatic write_config(input logic a, input tick_t d, input tick_t c,
			input tick_t r, input tick_t h);
		write_reg(CFG_PRESS_LEVEL, tick_t'(a));
		write_reg(CFG_DEBOUNCE, d);
		write_reg(CFG_CLICK, c);
		write_reg(CFG_RELEASE, r);
		write_reg(CFG_HOLD, h);
	endtask

	task automatic wait_drained();
		while (ticks_taken != ticks_pushed || tick_reports.size() != 0)
			@(posedge clk);
		// results are registered twice inside the block
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input logic a, input tick_t d, input tick_t c,
			input tick_t r, input tick_t h, input int n, input bit squeeze);
		int goal;
		write_config(a, d, c, r, h);
		goal = ticks_pushed + n;
		while (ticks_pushed < goal)
			push_gesture();
		if (squeeze)
			holdoff_reqs++;
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero debounce, single, double, hold and release
		write_config(1'b1, 16'd0, 16'd4, 16'd3, 16'd5);
		push_segment(1'b0, 1, 0);
		push_segment(1'b1, 2, 0);
		push_segment(1'b0, 4, 0);
		push_segment(1'b1, 2, 0);
		push_segment(1'b0, 1, 0);
		push_segment(1'b1, 1, 0);
		push_segment(1'b0, 2, 0);
		push_segment(1'b1, 7, 0);
		push_segment(1'b0, 4, 0);
		wait_drained();

		run_random(1'b0, 16'd2, 16'd6, 16'd5, 16'd8, 130, 1'b1);
		run_random(1'b1, 16'd1, 16'd3, 16'd2, 16'd4, 130, 1'b0);
		run_random(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 130, 1'b0);
		run_random(1'b1, 16'd3, 16'd10, 16'd8, 16'd12, 130, 1'b0);
		run_random(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40, 1'b0);
		run_random(1'b1, 16'd0, 16'd5, 16'hFFFF, 16'd0, 120, 1'b0);
		run_random(1'b0, 16'd2, 16'd1, 16'd0, 16'hFFFF, 120, 1'b0);
		run_random(1'b1, 16'd2, 16'd7, 16'd6, 16'd15, 130, 1'b0);

		repeat (10) @(posedge clk);
		if (tick_reports.size() != 0) begin
			$display("%0d expected result beats never arrived", tick_reports.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sender: bursts of beats with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pin_level <= 1'b0;
			edge_seen <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				classify_tick(pin_level, edge_seen);
				ticks_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (ticks_to_send.size() != 0) begin
					next_tick = ticks_to_send.pop_front();
					in_valid <= 1'b1;
					pin_level <= next_tick.pin;
					edge_seen <= next_tick.edg;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 60);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern is picked anew at random intervals, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_kind_left == 0) begin
				stall_kind = stall_kind_t'($urandom_range(0, 3));
				stall_kind_left = $urandom_range(16, 96);
			end else begin
				stall_kind_left--;
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else if (holdoff_served != holdoff_reqs) begin
				holdoff_served++;
				holdoff_left = HOLDOFF_CYCLES;
				out_stall <= 1'b1;
			end else begin
				case (stall_kind)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (tick_reports.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected result beat: event %0d power_off %b level %b",
						event_res, power_off, level_now);
			end else begin
				want = tick_reports.pop_front();
				if (event_res !== want.ev || power_off !== want.pwr || level_now !== want.lvl) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("result mismatch: event %0d/%0d power_off %b/%b level %b/%b (exp/got)",
							want.ev, event_res, want.pwr, power_off, want.lvl, level_now);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
src/bchc_pkg.sv
src/bchc_debounce.sv
src/bchc_phase.sv
src/button_click_hold_classifier.sv
verif/testbench.sv
